FILE: rtl/core/assert_macros.svh
// Assertion macros for the RTL files that carry checks; the decoder top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HSD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define HSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/hsd_pkg.sv
`default_nettype none

package hsd_pkg;

   // Field and port widths.
   localparam int CW_W       = 63;
   localparam int DATA_W     = 57;
   localparam int SYN_W      = 6;
   localparam int CNT_W      = 6;
   localparam int CHK_W      = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register map: the register index is the word address.
   localparam logic REG_DATA_BITS = 1'b0;

   localparam logic [CNT_W-1:0] DATA_BITS_RESET = 6'd8;

   // Code geometry that the decoder needs: codeword length and check bit count.
   typedef struct packed {
      logic [CNT_W-1:0] n;
      logic [CHK_W-1:0] k;
   } cfg_type;

   // Clamp the programmed width and derive the check bit count and the length.
   function automatic cfg_type derive_cfg(logic [CNT_W-1:0] raw, logic [CNT_W-1:0] max_d);
      logic [CNT_W-1:0] d;
      logic [CHK_W-1:0] k;
      cfg_type          c;
      d = raw;
      if (d == '0) begin
         d = 6'd1;
      end
      if (d > max_d) begin
         d = max_d;
      end
      k = '0;
      for (int s = 0; s < 6; s++) begin
         if ((7'd1 << k) < ({1'b0, d} + 7'(k) + 7'd1)) begin
            k = k + 3'd1;
         end
      end
      c.n = d + 6'(k);
      c.k = k;
      return c;
   endfunction

   // Positions (one-based index has bit i set) that take part in parity i.
   // The check position itself is included, so the XOR gives the syndrome bit.
   function automatic logic [CW_W-1:0] parity_mask(int i);
      logic [CW_W-1:0] m;
      for (int j = 0; j < CW_W; j++) begin
         m[j] = (((j + 1) >> i) & 1) != 0;
      end
      return m;
   endfunction

   // Zero-based codeword bit that holds data bit j (the j-th non-power-of-two).
   function automatic int data_pos(int j);
      int cnt;
      int res;
      cnt = 0;
      res = 0;
      for (int p = 1; p <= CW_W; p++) begin
         if ((p & (p - 1)) != 0) begin
            if (cnt == j) begin
               res = p - 1;
            end
            cnt = cnt + 1;
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hsd_csr.sv
`default_nettype none

module hsd_csr import hsd_pkg::*; #(
   parameter int MAX_DATA_BITS = 57
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   localparam logic [CNT_W-1:0] MaxD = CNT_W'(MAX_DATA_BITS);

   logic [CNT_W-1:0] data_bits_ff;
   logic [CNT_W-1:0] data_bits_in;
   cfg_type          cfg_ff;
   cfg_type          cfg_in;
   logic             wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_DATA_BITS);

   // The derived geometry is worked out when the register is written or reset, not on every use.
   always_comb begin
      data_bits_in = data_bits_ff;
      cfg_in       = cfg_ff;
      if (wr_en) begin
         data_bits_in = pwdata[CNT_W-1:0];
         cfg_in       = derive_cfg(pwdata[CNT_W-1:0], MaxD);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_bits_ff <= DATA_BITS_RESET;
         cfg_ff       <= derive_cfg(DATA_BITS_RESET, MaxD);
      end else begin
         data_bits_ff <= data_bits_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Read back the value as written.
   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_DATA_BITS) begin
         prdata = {{(CSR_DATA_W-CNT_W){1'b0}}, data_bits_ff};
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/core/hsd_core.sv
`default_nettype none

module hsd_core import hsd_pkg::*; (
   input  cfg_type                cfg,
   input  wire logic [CW_W-1:0]   codeword,
   output logic      [DATA_W-1:0] data,
   output logic      [SYN_W-1:0]  syndrome,
   output logic                   corrected,
   output logic                   syndrome_out_of_range
);

   logic [CW_W-1:0] len_mask;
   logic [CW_W-1:0] cw;
   logic [CW_W-1:0] flip;
   logic [CW_W-1:0] cw_fixed;

   // Positions beyond the codeword length are ignored.
   for (genvar j = 0; j < CW_W; j++) begin : g_mask
      assign len_mask[j] = (CNT_W'(j) < cfg.n);
   end

   assign cw = codeword & len_mask;

   // One parity tree per syndrome bit; bits at and above the check count stay low.
   for (genvar i = 0; i < SYN_W; i++) begin : g_syn
      localparam logic [CW_W-1:0] PMask = parity_mask(i);
      assign syndrome[i] = (CHK_W'(i) < cfg.k) && (^(cw & PMask));
   end

   // A syndrome past the end of the codeword is reported but not corrected.
   assign syndrome_out_of_range = (syndrome > cfg.n);
   assign corrected             = (syndrome != '0) && !syndrome_out_of_range;

   always_comb begin
      flip = '0;
      if (corrected) begin
         flip = {{(CW_W-1){1'b0}}, 1'b1} << (syndrome - SYN_W'(1));
      end
   end

   assign cw_fixed = cw ^ flip;

   // Data bits sit at the non-power-of-two positions in order.
   for (genvar g = 0; g < DATA_W; g++) begin : g_data
      localparam int Pos = data_pos(g);
      assign data[g] = cw_fixed[Pos];
   end

endmodule

`default_nettype wire

FILE: rtl/core/hamming_sec_decoder.sv
// Single-error-correcting Hamming decoder. Each beat on the req channel carries one
// codeword (position p in bit p-1, check bits at powers of two); the matching rsp beat
// returns the data bits after correction, the syndrome, a flag that a bit was flipped and
// a flag for a syndrome that points past the codeword end (nothing is flipped then).
// The data width comes from the data_bits register at address 0 (1 to MAX_DATA_BITS, 0
// is taken as 1, reset value 8); write it only while no beats are in flight. The block
// takes one codeword every cycle while req_stall is low; a beat passes through one input
// register and one result register, with the parity trees and the correction between
// them. A double error is miscorrected, as is usual for a plain SEC code.
`default_nettype none

module hamming_sec_decoder import hsd_pkg::*; #(
   parameter int MAX_DATA_BITS = 57
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Codeword channel.
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [CW_W-1:0]       req_codeword,
   // Result channel.
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [DATA_W-1:0]     rsp_data,
   output logic      [SYN_W-1:0]      rsp_syndrome,
   output logic                       rsp_corrected,
   output logic                       rsp_syndrome_out_of_range,
   // Register port.
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

`include "assert_macros.svh"

   cfg_type           cfg;

   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic [CW_W-1:0]   s1_cw_ff;
   logic [CW_W-1:0]   s1_cw_in;
   logic              s2_valid_ff;
   logic              s2_valid_in;
   logic [DATA_W-1:0] s2_data_ff;
   logic [DATA_W-1:0] s2_data_in;
   logic [SYN_W-1:0]  s2_syn_ff;
   logic [SYN_W-1:0]  s2_syn_in;
   logic              s2_corr_ff;
   logic              s2_corr_in;
   logic              s2_oor_ff;
   logic              s2_oor_in;

   logic              s1_free;
   logic              s2_free;
   logic [DATA_W-1:0] dec_data;
   logic [SYN_W-1:0]  dec_syn;
   logic              dec_corr;
   logic              dec_oor;

   hsd_csr #(
      .MAX_DATA_BITS(MAX_DATA_BITS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   hsd_core u_core (
      .cfg                   (cfg),
      .codeword              (s1_cw_ff),
      .data                  (dec_data),
      .syndrome              (dec_syn),
      .corrected             (dec_corr),
      .syndrome_out_of_range (dec_oor)
   );

   // A stage may load when it is empty or its contents move on in the same cycle.
   assign s2_free   = !s2_valid_ff || !rsp_stall;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = !s1_free;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_cw_in    = s1_cw_ff;
      if (s1_free) begin
         s1_valid_in = req_valid;
         s1_cw_in    = req_codeword;
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_data_in  = s2_data_ff;
      s2_syn_in   = s2_syn_ff;
      s2_corr_in  = s2_corr_ff;
      s2_oor_in   = s2_oor_ff;
      if (s2_free) begin
         s2_valid_in = s1_valid_ff;
         s2_data_in  = dec_data;
         s2_syn_in   = dec_syn;
         s2_corr_in  = dec_corr;
         s2_oor_in   = dec_oor;
      end
   end

   // Control flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_cw_ff   <= s1_cw_in;
      s2_data_ff <= s2_data_in;
      s2_syn_ff  <= s2_syn_in;
      s2_corr_ff <= s2_corr_in;
      s2_oor_ff  <= s2_oor_in;
   end

   assign rsp_valid                 = s2_valid_ff;
   assign rsp_data                  = s2_data_ff;
   assign rsp_syndrome              = s2_syn_ff;
   assign rsp_corrected             = s2_corr_ff;
   assign rsp_syndrome_out_of_range = s2_oor_ff;

   // An accepted beat is held in the input register in the next cycle.
   `HSD_ASSERT_NEXT(a_accept_lands, clock, reset, req_valid && !req_stall, s1_valid_ff, "accepted beat lost")

   // A nonzero syndrome either corrects or is flagged, never both.
   `HSD_ASSERT_SAME(a_syn_outcome, clock, reset, rsp_valid, (rsp_syndrome != '0) == (rsp_corrected ^ rsp_syndrome_out_of_range), "syndrome outcome inconsistent")

   // The out-of-range flag agrees with the programmed codeword length.
   `HSD_ASSERT_SAME(a_oor_len, clock, reset, rsp_valid && rsp_syndrome_out_of_range, rsp_syndrome > cfg.n, "out-of-range flag without long syndrome")

endmodule

`default_nettype wire
